// ===== sv/dwpw_pkg.sv =====
package dwpw_pkg;

    // Cursor and window coordinate width
    localparam int unsigned CURSOR_W = 10;
    localparam int unsigned COLOUR_W = 8;
    localparam int unsigned BUS_W    = 24;

    // Packed result width, padded up to whole bytes
    localparam int unsigned RESULT_W      = 2 * CURSOR_W + 3 * COLOUR_W;
    localparam int unsigned RESULT_BYTE_W = ((RESULT_W + 7) / 8) * 8;

    typedef logic [CURSOR_W-1:0] cursor_t;
    typedef logic [COLOUR_W-1:0] colour_t;
    typedef logic [BUS_W-1:0]    bus_word_t;

    // Command opcodes, carried in the low nibble of a command word
    typedef enum logic [3:0] {
        OP_COLUMN_WINDOW = 4'h0,
        OP_ROW_WINDOW    = 4'h1
    } opcode_t;

    // One axis of the write window
    typedef struct packed {
        cursor_t start;
        cursor_t stop;
        cursor_t cursor;
    } window_axis_t;

endpackage

// ===== sv/display_window_pixel_writer_top.sv =====
// Path: a pixel accepted on s_axis passes the input register, then the result
//   register, and appears on m_axis from there; commands and disabled items give
//   no result.
// Throughput: one transaction per cycle, except while a pixel waits on a full result register that m_axis stalls.
// Reset: rst_n is asynchronous, active low; it clears both windows, both cursors
//   and all valid flags.
module display_window_pixel_writer_top #(
    parameter int unsigned FRAME_WIDTH  = 640,
    parameter int unsigned FRAME_HEIGHT = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bus_word[23:0]
    input  logic [1:0]  s_axis_tuser,   // [0] enable, [1] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pixel_row[9:0], pixel_column[19:10], red[27:20],
                                        // green[35:28], blue[43:36], zero pad[47:44]
    output logic [0:0]  m_axis_tuser    // [0] outside_frame
);

    import dwpw_pkg::*;

    localparam logic [CURSOR_W:0] FrameWidth  = (CURSOR_W + 1)'(FRAME_WIDTH);
    localparam logic [CURSOR_W:0] FrameHeight = (CURSOR_W + 1)'(FRAME_HEIGHT);

    // Input register
    logic      in_valid_reg;
    logic      in_enable_reg;
    logic      in_mode_reg;
    bus_word_t in_word_reg;

    // Window state
    window_axis_t col_reg, col_next;
    window_axis_t row_reg, row_next;

    // Result register
    logic                     out_valid_reg;
    logic [RESULT_BYTE_W-1:0] out_data_reg, out_data_next;
    logic                     out_outside_reg, out_outside_next;

    logic    is_pixel;
    logic    is_command;
    logic    out_free;
    logic    stage_move;
    cursor_t cmd_start;
    cursor_t cmd_stop;
    opcode_t cmd_op;

    // Decode of the held item
    assign is_pixel   = in_valid_reg && in_enable_reg && !in_mode_reg;
    assign is_command = in_valid_reg && in_enable_reg && in_mode_reg;
    assign cmd_start  = in_word_reg[23:14];
    assign cmd_stop   = in_word_reg[13:4];
    assign cmd_op     = opcode_t'(in_word_reg[3:0]);

    // Handshake: result slot frees when empty or taken this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stage_move    = in_valid_reg && (!is_pixel || out_free);
    assign s_axis_tready = !in_valid_reg || stage_move;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_enable_reg <= s_axis_tuser[0];
            in_mode_reg   <= s_axis_tuser[1];
            in_word_reg   <= s_axis_tdata;
        end
    end

    // Window and cursor update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (stage_move && is_command)
        begin
            case (cmd_op)
                OP_COLUMN_WINDOW:
                begin
                    col_next.start  = cmd_start;
                    col_next.stop   = cmd_stop;
                    col_next.cursor = cmd_start;
                end
                OP_ROW_WINDOW:
                begin
                    row_next.start  = cmd_start;
                    row_next.stop   = cmd_stop;
                    row_next.cursor = cmd_start;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
        else if (stage_move && is_pixel)
        begin
            // Raster advance inside the window, wrapping at the 10-bit limit
            if (col_reg.cursor == col_reg.stop)
            begin
                col_next.cursor = col_reg.start;
                if (row_reg.cursor == row_reg.stop)
                begin
                    row_next.cursor = row_reg.start;
                end
                else
                begin
                    row_next.cursor = row_reg.cursor + 1'b1;
                end
            end
            else
            begin
                col_next.cursor = col_reg.cursor + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Result packing
    always_comb
    begin
        out_data_next    = '0;
        out_data_next[9:0]   = row_reg.cursor;
        out_data_next[19:10] = col_reg.cursor;
        out_data_next[27:20] = in_word_reg[23:16];
        out_data_next[35:28] = in_word_reg[15:8];
        out_data_next[43:36] = in_word_reg[7:0];
        out_outside_next = ({1'b0, row_reg.cursor} >= FrameHeight)
                        || ({1'b0, col_reg.cursor} >= FrameWidth);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_move && is_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_move && is_pixel)
        begin
            out_data_reg    <= out_data_next;
            out_outside_reg <= out_outside_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_outside_reg;

    // A result only appears after a pixel left the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_move && is_pixel))
        else $error("result without a pixel transaction");

    // A column window command puts the column cursor at the window start
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_move && is_command && cmd_op == OP_COLUMN_WINDOW)
        |=> (col_reg.cursor == col_reg.start))
        else $error("column cursor not moved to window start");

    // Inside the window the column cursor steps by one per pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_move && is_pixel && col_reg.cursor != col_reg.stop)
        |=> (col_reg.cursor == CURSOR_W'($past(col_reg.cursor) + 1'b1)))
        else $error("column cursor did not step");

    // Outside flag agrees with the coordinates it was sent with
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] ==
            (({1'b0, m_axis_tdata[9:0]} >= FrameHeight)
             || ({1'b0, m_axis_tdata[19:10]} >= FrameWidth))))
        else $error("outside_frame disagrees with coordinates");

endmodule

// ===== tb/sv/dwpw_pixel_checker.sv =====
`timescale 1ns / 100ps

// Watches both stream channels, works out the framebuffer write due for each
// accepted bus transaction and compares every emitted write with the oldest one due.
module dwpw_pixel_checker #(
    parameter int unsigned FRAME_WIDTH  = 640,
    parameter int unsigned FRAME_HEIGHT = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bus_word[23:0]
    input  logic [1:0]  s_axis_tuser,   // [0] enable, [1] mode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // pixel_row[9:0], pixel_column[19:10], red[27:20],
                                        // green[35:28], blue[43:36], zero pad[47:44]
    input  logic [0:0]  m_axis_tuser,   // [0] outside_frame
    output int          mismatches,
    output int          pending
);

    import dwpw_pkg::*;

    typedef struct packed {
        cursor_t row;
        cursor_t column;
        colour_t red;
        colour_t green;
        colour_t blue;
        logic    outside;
    } pixel_write_t;

    window_axis_t column_axis;
    window_axis_t row_axis;
    pixel_write_t writes_due[$];
    int           fault_total;

    // Log the first few faults in full, count the rest
    function automatic void note_fault(string what, pixel_write_t want, pixel_write_t got);
        if (fault_total < 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("    expected row %0d col %0d rgb %02h%02h%02h outside %0b",
                     want.row, want.column, want.red, want.green, want.blue, want.outside);
            $display("    actual   row %0d col %0d rgb %02h%02h%02h outside %0b",
                     got.row, got.column, got.red, got.green, got.blue, got.outside);
        end
        fault_total++;
    endfunction

    // Raster advance inside the window; cursors wrap naturally at 10 bits
    function automatic void step_write_position();
        if (column_axis.cursor == column_axis.stop)
        begin
            column_axis.cursor = column_axis.start;
            if (row_axis.cursor == row_axis.stop)
                row_axis.cursor = row_axis.start;
            else
                row_axis.cursor = row_axis.cursor + 1'b1;
        end
        else
        begin
            column_axis.cursor = column_axis.cursor + 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_write_t got;
        pixel_write_t want;
        if (!rst_n)
        begin
            column_axis = '0;
            row_axis    = '0;
            writes_due.delete();
            fault_total = 0;
            mismatches  <= 0;
            pending     <= 0;
        end
        else
        begin
            // Emitted write: compare with the oldest one due
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row     = m_axis_tdata[9:0];
                got.column  = m_axis_tdata[19:10];
                got.red     = m_axis_tdata[27:20];
                got.green   = m_axis_tdata[35:28];
                got.blue    = m_axis_tdata[43:36];
                got.outside = m_axis_tuser[0];
                if (writes_due.size() == 0)
                begin
                    note_fault("pixel write with none due", '0, got);
                end
                else
                begin
                    want = writes_due.pop_front();
                    if (got.row !== want.row || got.column !== want.column ||
                        got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.outside !== want.outside)
                        note_fault("pixel write mismatch", want, got);
                end
            end

            // Accepted bus transaction: update the window or predict a write
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser[0])
            begin
                if (s_axis_tuser[1])
                begin
                    case (s_axis_tdata[3:0])
                        OP_COLUMN_WINDOW:
                        begin
                            column_axis.start  = s_axis_tdata[23:14];
                            column_axis.stop   = s_axis_tdata[13:4];
                            column_axis.cursor = s_axis_tdata[23:14];
                        end
                        OP_ROW_WINDOW:
                        begin
                            row_axis.start  = s_axis_tdata[23:14];
                            row_axis.stop   = s_axis_tdata[13:4];
                            row_axis.cursor = s_axis_tdata[23:14];
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    want.row     = row_axis.cursor;
                    want.column  = column_axis.cursor;
                    want.red     = s_axis_tdata[23:16];
                    want.green   = s_axis_tdata[15:8];
                    want.blue    = s_axis_tdata[7:0];
                    want.outside = (row_axis.cursor >= FRAME_HEIGHT) ||
                                   (column_axis.cursor >= FRAME_WIDTH);
                    writes_due.push_back(want);
                    step_write_position();
                end
            end

            mismatches <= fault_total;
            pending    <= writes_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_display_window_pixel_writer_top.sv =====
`timescale 1ns / 100ps

module tb_display_window_pixel_writer_top;

    import dwpw_pkg::*;

    localparam int unsigned FRAME_WIDTH  = 640;
    localparam int unsigned FRAME_HEIGHT = 480;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // bus_word[23:0]
    logic [1:0]  s_axis_tuser  = '0;   // [0] enable, [1] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // pixel_row[9:0], pixel_column[19:10], red[27:20],
                                       // green[35:28], blue[43:36], zero pad[47:44]
    logic [0:0]  m_axis_tuser;         // [0] outside_frame

    int mismatches;
    int pending;
    int sender_idle_pct   = 16;
    int receiver_idle_pct = 83;

    display_window_pixel_writer_top #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dwpw_pixel_checker #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) pixel_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[display_window_pixel_writer_top] ERROR");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

    // One bus transaction, with random idle cycles ahead of it
    task automatic send_item(input logic enable, input logic mode, input bus_word_t word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {mode, enable};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_window(input opcode_t op, input cursor_t first, input cursor_t last);
        send_item(1'b1, 1'b1, {first, last, op});
    endtask

    task automatic send_pixel(input bus_word_t colour);
        send_item(1'b1, 1'b0, colour);
    endtask

    // Hold off the sender until every due write has come out
    task automatic wait_writes_done();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Window ranges biased towards wraps and the frame boundary
    function automatic void pick_window(input bit is_column, output cursor_t first,
                                        output cursor_t last);
        int frame_limit;
        frame_limit = is_column ? FRAME_WIDTH : FRAME_HEIGHT;
        case ($urandom_range(7))
            0, 1, 2:
            begin
                first = CURSOR_W'($urandom);
                last  = CURSOR_W'(first + $urandom_range(15));
            end
            3, 4:
            begin
                first = CURSOR_W'(frame_limit - $urandom_range(1, 4));
                last  = CURSOR_W'(first + $urandom_range(6));
            end
            5, 6:
            begin
                first = CURSOR_W'(1023 - $urandom_range(3));
                last  = CURSOR_W'($urandom_range(3));
            end
            default:
            begin
                first = CURSOR_W'($urandom);
                last  = CURSOR_W'($urandom);
            end
        endcase
    endfunction

    // Mostly window set-up followed by pixel runs, with some noise mixed in
    task automatic random_traffic(input int sender_pct, input int receiver_pct,
                                  input int target);
        int      counted;
        int      choice;
        int      run_len;
        cursor_t first;
        cursor_t last;
        counted = 0;
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        while (counted < target)
        begin
            choice = $urandom_range(99);
            if (choice < 8)
            begin
                pick_window(1'b1, first, last);
                send_window(OP_COLUMN_WINDOW, first, last);
                counted++;
            end
            else if (choice < 16)
            begin
                pick_window(1'b0, first, last);
                send_window(OP_ROW_WINDOW, first, last);
                counted++;
            end
            else if (choice < 20)
            begin
                send_item(1'b0, 1'($urandom_range(1)), BUS_W'($urandom));
            end
            else if (choice < 23)
            begin
                send_item(1'b1, 1'b1, {20'($urandom_range(20'hFFFFF)),
                                       4'($urandom_range(2, 15))});
            end
            else
            begin
                run_len = $urandom_range(1, 24);
                repeat (run_len)
                begin
                    if ($urandom_range(19) == 0)
                        send_item(1'b0, 1'($urandom_range(1)), BUS_W'($urandom));
                    send_pixel(BUS_W'($urandom));
                    counted++;
                end
            end
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: one-pixel window at the origin, extreme colours
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        // Disabled items and unknown opcodes leave everything alone
        send_item(1'b0, 1'b0, 24'h123456);
        send_item(1'b0, 1'b1, {10'd5, 10'd9, OP_COLUMN_WINDOW});
        send_item(1'b1, 1'b1, 24'hABCDE2);
        send_item(1'b1, 1'b1, 24'hFFFFFF);
        // Window straddling the bottom-right frame corner
        send_window(OP_COLUMN_WINDOW, 10'd638, 10'd640);
        send_window(OP_ROW_WINDOW, 10'd478, 10'd479);
        send_pixel(24'hFF0000);
        send_pixel(24'h00FF00);
        send_pixel(24'h0000FF);
        send_pixel(24'h5A5A5A);
        send_pixel(24'hA5A5A5);
        // Start beyond end on both axes, wrapping through 1023
        send_window(OP_COLUMN_WINDOW, 10'd1022, 10'd1);
        send_window(OP_ROW_WINDOW, 10'd1023, 10'd0);
        send_pixel(24'h010203);
        send_pixel(24'h102030);
        send_pixel(24'h800080);
        send_pixel(24'h7F7F7F);
        send_pixel(24'hC0FFEE);
        // Single top column, full-height row range
        send_window(OP_COLUMN_WINDOW, 10'd1023, 10'd1023);
        send_window(OP_ROW_WINDOW, 10'd0, 10'd1023);
        send_pixel(24'hFEDCBA);
        send_pixel(24'h0F0F0F);
        wait_writes_done();

        random_traffic(16, 83, 430);
        wait_writes_done();
        random_traffic(83, 16, 430);
        wait_writes_done();
        random_traffic(0, 0, 440);
        wait_writes_done();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[display_window_pixel_writer_top] OK");
        else
            $display("[display_window_pixel_writer_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dwpw_pkg.sv
sv/display_window_pixel_writer_top.sv
tb/sv/dwpw_pixel_checker.sv
tb/sv/tb_display_window_pixel_writer_top.sv
